// ===== design/kf_pkg.sv =====
package kf_pkg;

   localparam int CMD_WIDTH       = 2;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CMD_WIDTH-1:0] CMD_PREDICT = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_UPDATE  = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_RESTART = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INIT_ESTIMATE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INIT_VARIANCE = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROCESS_NOISE = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MEASURE_NOISE = 3'd3;

   // top level to core
   typedef struct packed {
      logic start;
      logic ack;
   } kf_ctl_type;

   // core to top level
   typedef struct packed {
      logic idle;
      logic done;
   } kf_sts_type;

endpackage

// ===== design/kf_alu.sv =====
module kf_alu #(
   parameter int WIDTH = 50
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  logic             sub,
   output logic [WIDTH-1:0] sum
);

   // two's complement add or subtract, shared by the add, subtract, divide and multiply steps of the sequencer
   assign sum = a + (b ^ {WIDTH{sub}}) + {{(WIDTH-1){1'b0}}, sub};

endmodule

// ===== design/kf_core.sv =====
module kf_core #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  kf_pkg::kf_ctl_type           ctl,
   output kf_pkg::kf_sts_type           sts,
   input  logic [kf_pkg::CMD_WIDTH-1:0] cmd,
   input  logic [DATA_WIDTH-1:0]        control_input,
   input  logic [DATA_WIDTH-1:0]        measurement,
   input  logic [DATA_WIDTH-1:0]        init_estimate,
   input  logic [DATA_WIDTH-1:0]        init_variance,
   input  logic [DATA_WIDTH-1:0]        process_noise,
   input  logic [DATA_WIDTH-1:0]        measure_noise,
   output logic [DATA_WIDTH-1:0]        estimate,
   output logic [DATA_WIDTH-1:0]        variance
);
   import kf_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int FB = FRAC_BITS;
   localparam int W  = DW + FB + 2;
   localparam int GW = FB + 1;
   localparam int CW = $clog2(FB + 1);
   localparam logic [DW-1:0] VAR_RESET = DW'(1) << FB;
   localparam logic [W-1:0]  ONE_W     = W'(1) << FB;

   typedef enum logic [3:0] {
      S_IDLE, S_PRED_X, S_PRED_P, S_DEN, S_DIV, S_DIFF, S_MUL_X,
      S_EST, S_GAIN_C, S_MUL_P, S_VAR, S_FINISH
   } state_type;

   state_type     state_ff, state_in;
   logic [DW-1:0] x_ff, x_in;
   logic [DW-1:0] p_ff, p_in;
   logic [DW-1:0] opnd_ff, opnd_in;
   logic [DW:0]   den_ff, den_in;
   logic [DW+1:0] r_ff, r_in;
   logic [GW-1:0] q_ff, q_in;
   logic [GW-1:0] mq_ff, mq_in;
   logic [DW:0]   md_ff, md_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [W-1:0]  alu_a, alu_b, alu_sum;
   logic          alu_sub;
   logic          ge;
   logic [DW+1:0] rem;

   function automatic logic [W-1:0] sext_dw(input logic [DW-1:0] v);
      sext_dw = {{(W-DW){v[DW-1]}}, v};
   endfunction

   function automatic logic [W-1:0] zext_dw(input logic [DW-1:0] v);
      zext_dw = {{(W-DW){1'b0}}, v};
   endfunction

   function automatic logic [DW-1:0] sat_s(input logic [W-1:0] s);
      logic [W-DW:0] top;
      top = s[W-1:DW-1];
      if ((&top) || !(|top)) sat_s = s[DW-1:0];
      else if (s[W-1])       sat_s = {1'b1, {(DW-1){1'b0}}};
      else                   sat_s = {1'b0, {(DW-1){1'b1}}};
   endfunction

   function automatic logic [DW-1:0] sat_u(input logic [W-1:0] s);
      sat_u = (|s[W-1:DW]) ? {DW{1'b1}} : s[DW-1:0];
   endfunction

   kf_alu #(.WIDTH(W)) u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .sub (alu_sub),
      .sum (alu_sum)
   );

   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         S_PRED_X: begin
            alu_a = sext_dw(x_ff);
            alu_b = sext_dw(opnd_ff);
         end
         S_PRED_P: begin
            alu_a = zext_dw(p_ff);
            alu_b = zext_dw(process_noise);
         end
         S_DEN: begin
            alu_a = zext_dw(p_ff);
            alu_b = zext_dw(measure_noise);
         end
         S_DIV: begin
            alu_a   = {{(W-DW-2){1'b0}}, r_ff};
            alu_b   = {{(W-DW-1){1'b0}}, den_ff};
            alu_sub = 1'b1;
         end
         S_DIFF: begin
            alu_a   = sext_dw(opnd_ff);
            alu_b   = sext_dw(x_ff);
            alu_sub = 1'b1;
         end
         S_MUL_X, S_MUL_P: begin
            alu_a = {acc_ff[W-2:0], 1'b0};
            alu_b = mq_ff[GW-1] ? {{(W-DW-1){md_ff[DW]}}, md_ff} : '0;
         end
         S_EST: begin
            alu_a = sext_dw(x_ff);
            alu_b = W'($signed(acc_ff) >>> FB);
         end
         S_GAIN_C: begin
            alu_a   = ONE_W;
            alu_b   = {{(W-GW){1'b0}}, q_ff};
            alu_sub = 1'b1;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   // restoring divide step: keep the trial remainder when it did not go negative
   assign ge  = ~alu_sum[W-1];
   assign rem = ge ? alu_sum[DW+1:0] : r_ff;

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      p_in     = p_ff;
      opnd_in  = opnd_ff;
      den_in   = den_ff;
      r_in     = r_ff;
      q_in     = q_ff;
      mq_in    = mq_ff;
      md_in    = md_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               opnd_in = (cmd == CMD_UPDATE) ? measurement : control_input;
               case (cmd)
                  CMD_PREDICT: state_in = S_PRED_X;
                  CMD_UPDATE:  state_in = S_DEN;
                  CMD_RESTART: begin
                     x_in     = init_estimate;
                     p_in     = init_variance;
                     state_in = S_FINISH;
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_PRED_X: begin
            x_in     = sat_s(alu_sum);
            state_in = S_PRED_P;
         end
         S_PRED_P: begin
            p_in     = sat_u(alu_sum);
            state_in = S_FINISH;
         end
         S_DEN: begin
            den_in   = alu_sum[DW:0];
            r_in     = {2'b00, p_ff};
            q_in     = '0;
            cnt_in   = CW'(FB);
            state_in = S_DIV;
         end
         S_DIV: begin
            r_in = {rem[DW:0], 1'b0};
            q_in = {q_ff[GW-2:0], ge};
            if (cnt_ff == '0) state_in = S_DIFF;
            else              cnt_in   = cnt_ff - 1'b1;
         end
         S_DIFF: begin
            // zero denominator forces a zero gain
            q_in     = (den_ff == '0) ? '0 : q_ff;
            mq_in    = (den_ff == '0) ? '0 : q_ff;
            md_in    = alu_sum[DW:0];
            acc_in   = '0;
            cnt_in   = CW'(FB);
            state_in = S_MUL_X;
         end
         S_MUL_X, S_MUL_P: begin
            acc_in = alu_sum;
            mq_in  = {mq_ff[GW-2:0], 1'b0};
            if (cnt_ff == '0) state_in = (state_ff == S_MUL_X) ? S_EST : S_VAR;
            else              cnt_in   = cnt_ff - 1'b1;
         end
         S_EST: begin
            x_in     = sat_s(alu_sum);
            state_in = S_GAIN_C;
         end
         S_GAIN_C: begin
            mq_in    = alu_sum[GW-1:0];
            md_in    = {1'b0, p_ff};
            acc_in   = '0;
            cnt_in   = CW'(FB);
            state_in = S_MUL_P;
         end
         S_VAR: begin
            p_in     = sat_u(W'(acc_ff >> FB));
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (ctl.ack) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         x_ff     <= '0;
         p_ff     <= VAR_RESET;
      end else begin
         state_ff <= state_in;
         x_ff     <= x_in;
         p_ff     <= p_in;
      end
      opnd_ff <= opnd_in;
      den_ff  <= den_in;
      r_ff    <= r_in;
      q_ff    <= q_in;
      mq_ff   <= mq_in;
      md_ff   <= md_in;
      acc_ff  <= acc_in;
      cnt_ff  <= cnt_in;
   end

   assign sts.idle = (state_ff == S_IDLE);
   assign sts.done = (state_ff == S_FINISH);
   assign estimate = x_ff;
   assign variance = p_ff;

endmodule

// ===== design/scalar_kalman_filter.sv =====
// Channel   Direction  Handshake             Payload
// req_      in         req_tvalid/tready     tuser = cmd, tdata = control, measurement
// rsp_      out        rsp_tvalid/tready     tdata = estimate, variance
// csr_      in         csr_wr_en             csr_index, csr_wdata
//
// Restart and unused commands go straight to the finish state; predict and update
// run on the one shared adder, which also runs the gain divide and both shift-add
// products a bit per cycle.
// One request is in work at a time; req_tready is high only while the core idles.
// A finished result waits in the core until the output register is free.
// Reset is synchronous, active high; it loads the default registers and state.
module scalar_kalman_filter #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // control_input, measurement, zero padding
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]  req_tdata,
   // cmd
   input  logic [kf_pkg::CMD_WIDTH-1:0]       req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // estimate_out, variance_out, zero padding
   output logic [((2*DATA_WIDTH+7)/8)*8-1:0]  rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic [kf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]              csr_wdata
);
   import kf_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int TW = ((2*DATA_WIDTH+7)/8)*8;
   localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;

   logic [DW-1:0] init_estimate_ff, init_variance_ff;
   logic [DW-1:0] process_noise_ff, measure_noise_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0] rsp_data_ff;
   logic [DW-1:0] estimate, variance;
   kf_ctl_type    ctl;
   kf_sts_type    sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_estimate_ff <= '0;
         init_variance_ff <= ONE;
         process_noise_ff <= '0;
         measure_noise_ff <= ONE;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_INIT_ESTIMATE: init_estimate_ff <= csr_wdata;
            CSR_INIT_VARIANCE: init_variance_ff <= csr_wdata;
            CSR_PROCESS_NOISE: process_noise_ff <= csr_wdata;
            CSR_MEASURE_NOISE: measure_noise_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = sts.idle;
   assign ctl.start  = req_tvalid & sts.idle;
   // hand the result over once the output register is empty or draining
   assign ctl.ack    = sts.done & (~rsp_valid_ff | rsp_tready);

   kf_core #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .sts           (sts),
      .cmd           (req_tuser),
      .control_input (req_tdata[DW-1:0]),
      .measurement   (req_tdata[2*DW-1:DW]),
      .init_estimate (init_estimate_ff),
      .init_variance (init_variance_ff),
      .process_noise (process_noise_ff),
      .measure_noise (measure_noise_ff),
      .estimate      (estimate),
      .variance      (variance)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.ack)         rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (ctl.ack) begin
         rsp_data_ff <= TW'({variance, estimate});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/kf_checker.sv =====
module kf_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [((2*DATA_WIDTH+7)/8)*8-1:0] rsp_tdata
);

   // one request in work at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a request was in work");

   // no result shows in the cycle right after a request when the output was empty
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared without processing time");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result dropped or changed");

endmodule

bind scalar_kalman_filter kf_checker #(.DATA_WIDTH(DATA_WIDTH)) u_kf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/sv/tb_scalar_kalman_filter.sv =====
`timescale 1ns / 100ps

module tb_scalar_kalman_filter;
   import kf_pkg::*;

   localparam int DATA_WIDTH     = 32;
   localparam int FRAC_BITS      = 16;
   localparam int TDATA_WIDTH    = ((2*DATA_WIDTH+7)/8)*8;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 105;

   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;

   localparam longint SAT_MAX   = 64'sd2147483647;
   localparam longint SAT_MIN   = -64'sd2147483648;
   localparam longint unsigned VAR_MAX   = 64'hFFFF_FFFF;
   localparam longint unsigned GAIN_ONE  = 64'd1 << FRAC_BITS;
   localparam logic [DATA_WIDTH-1:0] Q16_ONE = 32'h0001_0000;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]         cmd;
      logic signed [DATA_WIDTH-1:0] control;
      logic signed [DATA_WIDTH-1:0] measurement;
   } kf_request_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] estimate;
      logic [DATA_WIDTH-1:0]        variance;
   } kf_state_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [TDATA_WIDTH-1:0]     req_tdata  = '0;
   logic [CMD_WIDTH-1:0]       req_tuser  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [TDATA_WIDTH-1:0]     rsp_tdata;
   logic                       csr_wr_en  = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [DATA_WIDTH-1:0]      csr_wdata  = '0;

   scalar_kalman_filter #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // filter state and registers as the block should hold them
   logic signed [DATA_WIDTH-1:0] est_model     = '0;
   logic [DATA_WIDTH-1:0]        var_model     = Q16_ONE;
   logic signed [DATA_WIDTH-1:0] init_est_reg  = '0;
   logic [DATA_WIDTH-1:0]        init_var_reg  = Q16_ONE;
   logic [DATA_WIDTH-1:0]        proc_noise_reg = '0;
   logic [DATA_WIDTH-1:0]        meas_noise_reg = Q16_ONE;

   kf_request_type pending_reqs[$];
   kf_state_type   expected_states[$];

   int  queued_count   = 0;
   int  accepted_count = 0;
   int  checked_count  = 0;
   int  error_count    = 0;
   int  cmd_counts[4]  = '{default: 0};
   int  idle_cycles    = 0;
   int  send_gap       = 0;
   int  recv_stall     = 0;
   bit  quiet          = 1'b0;
   logic req_fired     = 1'b0;

   function automatic logic signed [DATA_WIDTH-1:0] clamp_signed(input longint v);
      if (v > SAT_MAX) return SAT_MAX[DATA_WIDTH-1:0];
      if (v < SAT_MIN) return SAT_MIN[DATA_WIDTH-1:0];
      return v[DATA_WIDTH-1:0];
   endfunction

   function automatic kf_state_type filter_step(input kf_request_type r);
      longint          x;
      longint          diff;
      longint          corr;
      longint unsigned p;
      longint unsigned den;
      longint unsigned gain;
      longint unsigned psum;
      kf_state_type    s;
      x = longint'(est_model);
      p = longint'(var_model) & VAR_MAX;
      case (r.cmd)
         CMD_PREDICT: begin
            est_model = clamp_signed(x + longint'(r.control));
            psum = p + (longint'(proc_noise_reg) & VAR_MAX);
            var_model = (psum > VAR_MAX) ? VAR_MAX[DATA_WIDTH-1:0] : psum[DATA_WIDTH-1:0];
         end
         CMD_UPDATE: begin
            den  = p + (longint'(meas_noise_reg) & VAR_MAX);
            gain = (den != 0) ? (p << FRAC_BITS) / den : 0;
            if (gain > GAIN_ONE) gain = GAIN_ONE;
            diff = longint'(r.measurement) - x;
            // arithmetic shift gives the floor of the product
            corr = (longint'(gain) * diff) >>> FRAC_BITS;
            est_model = clamp_signed(x + corr);
            psum = (p * (GAIN_ONE - gain)) >> FRAC_BITS;
            var_model = (psum > VAR_MAX) ? VAR_MAX[DATA_WIDTH-1:0] : psum[DATA_WIDTH-1:0];
         end
         CMD_RESTART: begin
            est_model = init_est_reg;
            var_model = init_var_reg;
         end
         default: ;
      endcase
      s.estimate = est_model;
      s.variance = var_model;
      return s;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      endcase
   endfunction

   function automatic logic [DATA_WIDTH-1:0] pick_noise();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(0, 32'h0004_0000);
      endcase
   endfunction

   task automatic queue_request(input logic [CMD_WIDTH-1:0] cmd,
                                input logic [DATA_WIDTH-1:0] control,
                                input logic [DATA_WIDTH-1:0] measurement);
      kf_request_type r;
      r.cmd = cmd;
      r.control = control;
      r.measurement = measurement;
      pending_reqs.insert(pending_reqs.size(), r);
      queued_count++;
   endtask

   task automatic queue_random_request();
      int                   pick;
      logic [CMD_WIDTH-1:0] cmd;
      pick = $urandom_range(0, 19);
      if (pick < 7)       cmd = CMD_PREDICT;
      else if (pick < 16) cmd = CMD_UPDATE;
      else if (pick < 19) cmd = CMD_RESTART;
      else                cmd = CMD_UNUSED;
      queue_request(cmd, pick_value(), pick_value());
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_idle();
      wait (accepted_count == queued_count && expected_states.size() == 0);
      @(negedge clock);
   endtask

   task automatic load_config(input logic [DATA_WIDTH-1:0] est0,
                              input logic [DATA_WIDTH-1:0] var0,
                              input logic [DATA_WIDTH-1:0] q,
                              input logic [DATA_WIDTH-1:0] r);
      write_csr(CSR_INIT_ESTIMATE, est0);
      write_csr(CSR_INIT_VARIANCE, var0);
      write_csr(CSR_PROCESS_NOISE, q);
      // out-of-range index must leave every register alone
      write_csr(CSR_MEASURE_NOISE + CSR_INDEX_WIDTH'($urandom_range(1, 4)), $urandom);
      write_csr(CSR_MEASURE_NOISE, r);
   endtask

   // request driver
   always @(negedge clock) begin
      kf_request_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fired) begin
         // hold until taken
      end else if (send_gap > 0) begin
         send_gap--;
         req_tvalid <= 1'b0;
      end else if (!quiet && pending_reqs.size() > 0 && $urandom_range(0, 7) == 0) begin
         send_gap = $urandom_range(1, 17) - 1;
         req_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
         r = pending_reqs.pop_front();
         req_tuser  <= r.cmd;
         req_tdata  <= {{(TDATA_WIDTH-2*DATA_WIDTH){1'b0}}, r.measurement, r.control};
         req_tvalid <= 1'b1;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         recv_stall = $urandom_range(1, 17) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: predict on accepted requests, check accepted results, track writes
   always @(posedge clock) begin
      kf_request_type r;
      kf_state_type   want;
      kf_state_type   got;
      req_fired <= req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            r.cmd = req_tuser;
            r.control = req_tdata[DATA_WIDTH-1:0];
            r.measurement = req_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
            expected_states.insert(expected_states.size(), filter_step(r));
            cmd_counts[r.cmd]++;
            accepted_count <= accepted_count + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.estimate = rsp_tdata[DATA_WIDTH-1:0];
            got.variance = rsp_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
            if (expected_states.size() == 0) begin
               $display("%0t: result with nothing expected: estimate %h variance %h",
                        $time, got.estimate, got.variance);
               error_count++;
            end else begin
               want = expected_states.pop_front();
               checked_count++;
               if (got.estimate !== want.estimate) begin
                  $display("%0t: estimate expected %h got %h",
                           $time, want.estimate, got.estimate);
                  error_count++;
               end
               if (got.variance !== want.variance) begin
                  $display("%0t: variance expected %h got %h",
                           $time, want.variance, got.variance);
                  error_count++;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_INIT_ESTIMATE: init_est_reg   <= csr_wdata;
               CSR_INIT_VARIANCE: init_var_reg   <= csr_wdata;
               CSR_PROCESS_NOISE: proc_noise_reg <= csr_wdata;
               CSR_MEASURE_NOISE: meas_noise_reg <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default registers: saturating predicts, extreme measurements
      queue_request(CMD_UPDATE,  '0, 32'h7FFF_FFFF);
      queue_request(CMD_UPDATE,  '0, 32'h8000_0000);
      queue_request(CMD_PREDICT, 32'h7FFF_FFFF, '0);
      queue_request(CMD_PREDICT, 32'h7FFF_FFFF, '0);
      queue_request(CMD_PREDICT, 32'h8000_0000, '0);
      queue_request(CMD_PREDICT, 32'h8000_0000, '0);
      queue_request(CMD_PREDICT, 32'h8000_0000, '0);
      queue_request(CMD_UNUSED,  $urandom, $urandom);
      queue_request(CMD_RESTART, $urandom, $urandom);
      queue_request(CMD_PREDICT, '0, $urandom);
      queue_request(CMD_UPDATE,  $urandom, Q16_ONE);
      queue_request(CMD_UPDATE,  $urandom, pick_value());
      wait_idle();

      // largest registers, no measurement noise: full gain, variance saturation
      load_config(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
      queue_request(CMD_RESTART, '0, '0);
      queue_request(CMD_PREDICT, 32'h7FFF_FFFF, '0);
      queue_request(CMD_PREDICT, '0, '0);
      queue_request(CMD_UPDATE,  '0, 32'h8000_0000);
      queue_request(CMD_UPDATE,  '0, 32'h7FFF_FFFF);
      queue_request(CMD_PREDICT, 32'h8000_0000, '0);
      queue_request(CMD_UNUSED,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      wait_idle();

      // zero variance and zero noise: gain denominator is zero
      load_config(32'h8000_0000, '0, '0, '0);
      queue_request(CMD_RESTART, '0, '0);
      queue_request(CMD_UPDATE,  '0, 32'h7FFF_FFFF);
      queue_request(CMD_PREDICT, 32'h8000_0000, '0);
      queue_request(CMD_UPDATE,  '0, '0);
      queue_request(CMD_UNUSED,  '0, '0);
      wait_idle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_config(pick_value(), pick_noise(), pick_noise(), pick_noise());
         if (phase == RANDOM_PHASES - 1) quiet = 1'b1;
         queue_request(CMD_RESTART, $urandom, $urandom);
         for (int i = 0; i < PHASE_ITEMS; i++) queue_random_request();
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d requests: %0d predict, %0d update, %0d restart, %0d unused",
               accepted_count, cmd_counts[CMD_PREDICT], cmd_counts[CMD_UPDATE],
               cmd_counts[CMD_RESTART], cmd_counts[CMD_UNUSED]);
      $display("%0d results checked over %0d register settings, %0d mismatches",
               checked_count, RANDOM_PHASES + 3, error_count);
      if (error_count == 0 && expected_states.size() == 0) begin
         $display("TB_OK");
      end else begin
         if (expected_states.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, expected_states.size());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
